// ===== sv/wlps_pkg.sv =====
// ----------------------------------------------------------------------------
// Latency window statistics package
// Shared constants, codes and types for the windowed latency statistics block.
// ----------------------------------------------------------------------------
package wlps_pkg;

  localparam int DefWindowDepth = 64;
  localparam int DefSourceCount = 8;

  localparam int LAT_W  = 32;
  localparam int TIME_W = 48;
  localparam int SRC_IN_W = 3;
  localparam int LIMIT_W = 7;

  localparam int HEALTHY_MIN_COUNT = 5;
  localparam int PCT_MEDIAN = 50;
  localparam int PCT_P95 = 95;
  localparam int PCT_P99 = 99;

  typedef enum logic [1:0] {
    OP_RECORD    = 2'd0,
    OP_QUERY     = 2'd1,
    OP_CLEAR_SRC = 2'd2,
    OP_CLEAR_ALL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_COUNT_LIMIT = 2'd0,
    REG_TIME_SPAN   = 2'd1,
    REG_HEALTH_LIM  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== sv/wlps_cell.sv =====
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one latency value; keeps the smaller of held and incoming values and
// passes the larger one on, or shifts its neighbor's value down.
// ----------------------------------------------------------------------------
module wlps_cell import wlps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic             in_valid,
  input  logic [LAT_W-1:0] in_data,
  input  logic             right_valid,
  input  logic [LAT_W-1:0] right_data,
  output logic             held_valid,
  output logic [LAT_W-1:0] held_data,
  output logic             pass_valid,
  output logic [LAT_W-1:0] pass_data
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (ctl.shift) begin
      held_valid <= right_valid;
      held_data  <= right_data;
      pass_valid <= 1'b0;
    end else begin
      pass_valid <= in_valid && held_valid;
      if (in_valid) begin
        if (!held_valid) begin
          held_valid <= 1'b1;
          held_data  <= in_data;
        end else if (in_data < held_data) begin
          held_data <= in_data;
          pass_data <= held_data;
        end else begin
          pass_data <= in_data;
        end
      end
    end
  end

endmodule

// ===== sv/wlps_div.sv =====
// ----------------------------------------------------------------------------
// Sequential divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wlps_div import wlps_pkg::*; #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] steps;
  logic             busy;
  logic [DEN_W:0]   rem_sh;

  assign rem_sh = {rem[DEN_W-1:0], quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      quot  <= num;
      den_r <= den;
      rem   <= '0;
      steps <= '0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem  <= rem_sh - {1'b0, den_r};
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
      steps <= steps + 1'b1;
      if (steps == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/windowed_latency_percentile_stats.sv =====
// ----------------------------------------------------------------------------
// Windowed latency percentile statistics
// Per-source sample windows with min, max, mean and p50/p95/p99 statistics.
// ----------------------------------------------------------------------------
// Query and clear items pass through the decode and done states before their result
// shows. A record that rescans k >= 1 samples and keeps m passes through a read and
// an evaluate state per rescanned sample, the flush and readout of the cell row, and
// waits for the 39-step divider for the mean. The next item can be taken in the
// same cycle in which the result shows.
// Synchronous reset empties all windows and restores the register defaults.
module windowed_latency_percentile_stats import wlps_pkg::*; #(
  parameter int WINDOW_DEPTH = DefWindowDepth,
  parameter int SOURCE_COUNT = DefSourceCount
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // source_id, latency_ns, sample_time
  input  logic [1:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,   // stats_valid, window fill, min_latency,
                                  // largest latency, mean_latency, median_latency,
                                  // p95_latency, p99_latency, last_update_time,
                                  // healthy
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int IW     = CNT_W + 1;
  localparam int SRC_W  = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int ADDR_W = (SOURCE_COUNT * WINDOW_DEPTH > 1) ?
                          $clog2(SOURCE_COUNT * WINDOW_DEPTH) : 1;
  localparam int MEM_D  = SOURCE_COUNT * WINDOW_DEPTH;
  localparam int SUM_W  = LAT_W + CNT_W;
  localparam int KW     = CNT_W + 8;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PREP, S_RD, S_EVAL, S_FLUSH, S_SCAN, S_DIVW, S_DONE
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0] window_count_limit;
  logic [TIME_W-1:0]  window_time_span;
  logic [LAT_W-1:0]   healthy_latency_limit;

  logic [1:0]        op;
  logic [SRC_W-1:0]  sidx;
  logic              in_range;
  logic [LAT_W-1:0]  lat;
  logic [TIME_W-1:0] now;

  logic [CNT_W-1:0]  fill [SOURCE_COUNT];
  logic [LAT_W-1:0]  st_min [SOURCE_COUNT];
  logic [LAT_W-1:0]  st_max [SOURCE_COUNT];
  logic [LAT_W-1:0]  st_mean [SOURCE_COUNT];
  logic [LAT_W-1:0]  st_p50 [SOURCE_COUNT];
  logic [LAT_W-1:0]  st_p95 [SOURCE_COUNT];
  logic [LAT_W-1:0]  st_p99 [SOURCE_COUNT];
  logic [TIME_W-1:0] st_time [SOURCE_COUNT];

  logic [LAT_W-1:0]  mem_lat [MEM_D];
  logic [TIME_W-1:0] mem_time [MEM_D];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [LAT_W-1:0]  rd_lat;
  logic [TIME_W-1:0] rd_time;

  logic [IW-1:0]    n;
  logic [IW-1:0]    total;
  logic [IW-1:0]    idx;
  logic [CNT_W-1:0] m;
  logic [IW-1:0]    flush_cnt;
  logic [SUM_W-1:0] sum;
  logic             feed_valid;
  logic [LAT_W-1:0] feed_data;

  logic [CNT_W-1:0] k;
  logic [KW-1:0]    k100;
  logic [KW-1:0]    prod50, prod95, prod99;
  logic [LAT_W-1:0] r_min, r_max, r_p50, r_p95, r_p99;

  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quot;

  logic [LAT_W-1:0]  cur_lat;
  logic [TIME_W-1:0] cur_time;
  logic              cur_keep;

  logic [CNT_W-1:0] lim_c;
  logic [IW-1:0]    n_c;
  logic [IW-1:0]    keep_c;
  logic [255:0]     result_c;

  cell_ctl_t        ctl;
  logic             held_v [WINDOW_DEPTH];
  logic [LAT_W-1:0] held_d [WINDOW_DEPTH];
  logic             pass_v [WINDOW_DEPTH];
  logic [LAT_W-1:0] pass_d [WINDOW_DEPTH];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  assign ctl.clr   = (state == S_PREP);
  assign ctl.shift = (state == S_SCAN);

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    logic             iv, rv;
    logic [LAT_W-1:0] id, rdv;
    if (g == 0) begin : g_head
      assign iv = feed_valid;
      assign id = feed_data;
    end else begin : g_body
      assign iv = pass_v[g-1];
      assign id = pass_d[g-1];
    end
    if (g == WINDOW_DEPTH - 1) begin : g_tail
      assign rv  = 1'b0;
      assign rdv = '0;
    end else begin : g_link
      assign rv  = held_v[g+1];
      assign rdv = held_d[g+1];
    end
    wlps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .in_valid   (iv),
      .in_data    (id),
      .right_valid(rv),
      .right_data (rdv),
      .held_valid (held_v[g]),
      .held_data  (held_d[g]),
      .pass_valid (pass_v[g]),
      .pass_data  (pass_d[g])
    );
  end

  wlps_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (sum),
    .den  (m),
    .done (div_done),
    .quot (div_quot)
  );

  assign div_start = (state == S_FLUSH) && (flush_cnt == IW'(WINDOW_DEPTH + 1)) &&
                     (m != '0);

  always_comb begin
    if (32'(window_count_limit) > 32'(WINDOW_DEPTH)) begin
      lim_c = CNT_W'(WINDOW_DEPTH);
    end else begin
      lim_c = CNT_W'(window_count_limit);
    end
    n_c = IW'(fill[sidx]);
    if (IW'(n_c + 1'b1) > IW'(lim_c)) begin
      keep_c = IW'(lim_c);
    end else begin
      keep_c = IW'(n_c + 1'b1);
    end
  end

  always_comb begin
    if (idx == n) begin
      cur_lat  = lat;
      cur_time = now;
    end else begin
      cur_lat  = rd_lat;
      cur_time = rd_time;
    end
    cur_keep  = ({1'b0, cur_time} + {1'b0, window_time_span}) >= {1'b0, now};
    mem_we    = (state == S_EVAL) && cur_keep;
    mem_waddr = ADDR_W'(32'(sidx) * WINDOW_DEPTH + 32'(m));
    mem_raddr = ADDR_W'(32'(sidx) * WINDOW_DEPTH + 32'(idx));
  end

  always_comb begin
    result_c = '0;
    if (in_range) begin
      result_c[0]       = fill[sidx] != '0;
      result_c[7:1]     = 7'(fill[sidx]);
      result_c[39:8]    = st_min[sidx];
      result_c[71:40]   = st_max[sidx];
      result_c[103:72]  = st_mean[sidx];
      result_c[135:104] = st_p50[sidx];
      result_c[167:136] = st_p95[sidx];
      result_c[199:168] = st_p99[sidx];
      result_c[247:200] = st_time[sidx];
      result_c[248]     = (32'(fill[sidx]) >= 32'(HEALTHY_MIN_COUNT)) &&
                          (st_p95[sidx] <= healthy_latency_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_lat[mem_waddr]  <= cur_lat;
      mem_time[mem_waddr] <= cur_time;
    end
    rd_lat  <= mem_lat[mem_raddr];
    rd_time <= mem_time[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count_limit    <= LIMIT_W'(64);
      window_time_span      <= TIME_W'(1000000000);
      healthy_latency_limit <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COUNT_LIMIT: window_count_limit    <= cfg_data[LIMIT_W-1:0];
        REG_TIME_SPAN:   window_time_span      <= cfg_data[TIME_W-1:0];
        REG_HEALTH_LIM:  healthy_latency_limit <= cfg_data[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      feed_valid <= 1'b0;
      for (int s = 0; s < SOURCE_COUNT; s++) begin
        fill[s]    <= '0;
        st_min[s]  <= '0;
        st_max[s]  <= '0;
        st_mean[s] <= '0;
        st_p50[s]  <= '0;
        st_p95[s]  <= '0;
        st_p99[s]  <= '0;
        st_time[s] <= '0;
      end
    end else begin
      feed_valid <= (state == S_EVAL) && cur_keep;
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op       <= s_tuser;
            sidx     <= SRC_W'(s_tdata[2:0]);
            in_range <= 32'(s_tdata[2:0]) < 32'(SOURCE_COUNT);
            lat      <= s_tdata[34:3];
            now      <= s_tdata[82:35];
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (op == OP_RECORD && in_range) begin
            state <= S_PREP;
          end else begin
            state <= S_DONE;
            if (op == OP_CLEAR_ALL || (op == OP_CLEAR_SRC && in_range)) begin
              for (int s = 0; s < SOURCE_COUNT; s++) begin
                if (op == OP_CLEAR_ALL || SRC_W'(s) == sidx) begin
                  fill[s]    <= '0;
                  st_min[s]  <= '0;
                  st_max[s]  <= '0;
                  st_mean[s] <= '0;
                  st_p50[s]  <= '0;
                  st_p95[s]  <= '0;
                  st_p99[s]  <= '0;
                  st_time[s] <= '0;
                end
              end
            end
          end
        end
        S_PREP: begin
          n     <= n_c;
          total <= IW'(n_c + 1'b1);
          idx   <= IW'(n_c + 1'b1 - keep_c);
          m     <= '0;
          sum   <= '0;
          state <= (keep_c == '0) ? S_FLUSH : S_RD;
          flush_cnt <= '0;
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (cur_keep) begin
            feed_data <= cur_lat;
            sum       <= sum + SUM_W'(cur_lat);
            m         <= m + 1'b1;
          end
          idx <= idx + 1'b1;
          if (IW'(idx + 1'b1) == total) begin
            state     <= S_FLUSH;
            flush_cnt <= '0;
          end else begin
            state <= S_RD;
          end
        end
        S_FLUSH: begin
          flush_cnt <= flush_cnt + 1'b1;
          if (flush_cnt == IW'(WINDOW_DEPTH + 1)) begin
            if (m == '0) begin
              fill[sidx]    <= '0;
              st_min[sidx]  <= '0;
              st_max[sidx]  <= '0;
              st_mean[sidx] <= '0;
              st_p50[sidx]  <= '0;
              st_p95[sidx]  <= '0;
              st_p99[sidx]  <= '0;
              st_time[sidx] <= '0;
              state         <= S_DONE;
            end else begin
              k      <= '0;
              k100   <= '0;
              prod50 <= KW'(PCT_MEDIAN) * KW'(m - 1'b1);
              prod95 <= KW'(PCT_P95) * KW'(m - 1'b1);
              prod99 <= KW'(PCT_P99) * KW'(m - 1'b1);
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (k == '0) begin
            r_min <= held_d[0];
          end
          if (k100 <= prod50 && KW'(k100 + KW'(100)) > prod50) begin
            r_p50 <= held_d[0];
          end
          if (k100 <= prod95 && KW'(k100 + KW'(100)) > prod95) begin
            r_p95 <= held_d[0];
          end
          if (k100 <= prod99 && KW'(k100 + KW'(100)) > prod99) begin
            r_p99 <= held_d[0];
          end
          k    <= k + 1'b1;
          k100 <= KW'(k100 + KW'(100));
          if (k == CNT_W'(m - 1'b1)) begin
            r_max <= held_d[0];
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            fill[sidx]    <= m;
            st_min[sidx]  <= r_min;
            st_max[sidx]  <= r_max;
            st_mean[sidx] <= div_quot[LAT_W-1:0];
            st_p50[sidx]  <= r_p50;
            st_p95[sidx]  <= r_p95;
            st_p99[sidx]  <= r_p99;
            st_time[sidx] <= now;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result_c;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/wlps_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Checks result items and handshakes seen at the block's ports.
// ----------------------------------------------------------------------------
module wlps_port_props (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [255:0] m_tdata
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input accepted while an item is in work.");

  a_out_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result item changed.");

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[7:1] != 7'd0)))
    else $error("Stats valid flag disagrees with the window fill.");

  a_healthy_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[248] |-> m_tdata[7:1] >= 7'd5)
    else $error("Healthy reported with too few samples.");

  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:8] <= m_tdata[71:40])
    else $error("Minimum above maximum.");

endmodule

bind windowed_latency_percentile_stats wlps_port_props u_wlps_port_props (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
